FILE: hw/rtl/lcdfb_pkg.sv
package lcdfb_pkg;

   // Widths fixed by the frame format
   localparam int INDEX_WIDTH = 5;
   localparam int SEG_BYTES   = 8;
   localparam int SEG_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;

   // Blink counter: wraps after 9, indicators lit below the limit
   localparam logic [3:0] BLINK_LAST  = 4'd9;
   localparam logic [3:0] BLINK_LIMIT = 4'd5;

   // Divide by ten through reciprocal multiplies
   localparam logic [15:0] DIST_DIV10_MUL   = 16'd52429;
   localparam int          DIST_DIV10_SHIFT = 19;
   localparam logic [7:0]  SPD_DIV10_MUL    = 8'd205;
   localparam int          SPD_DIV10_SHIFT  = 11;
   localparam logic [3:0]  DIGIT_BASE       = 4'd10;
   localparam logic [15:0] DIST_HUNDRED     = 16'd100;

   // Segment masks
   localparam logic [7:0] SEG_TURN_LEFT  = 8'h20;
   localparam logic [7:0] SEG_TURN_RIGHT = 8'h01;
   localparam logic [7:0] SEG_NEAR_LIGHT = 8'h10;
   localparam logic [7:0] SEG_HALL_ERR   = 8'h40;
   localparam logic [7:0] SEG_BAR_ERR    = 8'h80;
   localparam logic [7:0] SEG_CTRL_ERR   = 8'h80;
   localparam logic [7:0] SEG_BRAKE      = 8'h80;
   localparam logic [7:0] SEG_BAT_FRAME  = 8'h81;
   localparam logic [7:0] SEG_BAT_FIRST  = 8'h01;
   localparam logic [7:0] SEG_BAT_L2     = 8'h03;
   localparam logic [7:0] SEG_BAT_L3     = 8'h07;
   localparam logic [7:0] SEG_BAT_L4     = 8'h0F;
   localparam logic [7:0] SEG_BAT_L5     = 8'h4F;
   localparam logic [7:0] SEG_DIST_UNIT  = 8'h10;
   localparam logic [7:0] SEG_DIST_HUND  = 8'h08;
   localparam logic [7:0] SEG_MODE1      = 8'h04;
   localparam logic [7:0] SEG_MODE2      = 8'h02;
   localparam logic [7:0] SEG_MODE3      = 8'h08;
   localparam logic [7:0] SEG_MODE4      = 8'h08;
   localparam logic [7:0] SEG_MODE_MASK3 = 8'h0E;

   // Battery levels and assist modes
   localparam logic [2:0] BAT_EMPTY = 3'd0;
   localparam logic [2:0] BAT_L1    = 3'd1;
   localparam logic [2:0] BAT_L2    = 3'd2;
   localparam logic [2:0] BAT_L3    = 3'd3;
   localparam logic [2:0] BAT_L4    = 3'd4;
   localparam logic [2:0] BAT_L5    = 3'd5;
   localparam logic [2:0] MODE_1    = 3'd1;
   localparam logic [2:0] MODE_2    = 3'd2;
   localparam logic [2:0] MODE_3    = 3'd3;
   localparam logic [2:0] MODE_4    = 3'd4;

   typedef struct packed {
      logic        turn_left;
      logic        turn_right;
      logic        near_light;
      logic        hall_error;
      logic        handlebar_error;
      logic        controller_error;
      logic        braked;
      logic [2:0]  battery_level;
      logic [15:0] distance;
      logic [7:0]  speed_value;
      logic [2:0]  speed_mode;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] byte_index;
      logic [7:0]             segment_byte;
      logic                   last_byte;
   } rsp_type;

   typedef logic [SEG_BYTES-1:0][7:0] frame_type;

   function automatic logic [7:0] dist_segments(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0: seg = 8'hF5;
         4'd1: seg = 8'h60;
         4'd2: seg = 8'hD3;
         4'd3: seg = 8'hF2;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'hB6;
         4'd6: seg = 8'hB7;
         4'd7: seg = 8'hE0;
         4'd8: seg = 8'hF7;
         4'd9: seg = 8'hF6;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] speed_segments(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0: seg = 8'h5F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h6B;
         4'd3: seg = 8'h2F;
         4'd4: seg = 8'h36;
         4'd5: seg = 8'h3D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h3F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

FILE: hw/rtl/lcdfb_front.sv
module lcdfb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  lcdfb_pkg::req_type   req_data,
   output logic                 frame_valid,
   input  logic                 frame_ready,
   output lcdfb_pkg::frame_type frame
);

   logic                s1_valid_ff;
   lcdfb_pkg::req_type  s1_snap_ff;
   logic [3:0]          s1_phase_ff;
   logic [12:0]         s1_dq_ff;
   logic [4:0]          s1_sq_ff;

   logic                s2_valid_ff;
   lcdfb_pkg::req_type  s2_snap_ff;
   logic [3:0]          s2_phase_ff;
   logic [12:0]         s2_dq_ff;
   logic [9:0]          s2_dqq_ff;
   logic [3:0]          s2_dones_ff;
   logic [3:0]          s2_sones_ff;
   logic [3:0]          s2_stens_ff;

   logic [3:0]  phase_ff;
   logic [3:0]  phase_in;
   logic        s1_ready;
   logic        s2_ready;
   logic        accept;
   logic [31:0] dist_prod;
   logic [15:0] spd_prod;
   logic [28:0] dq_prod;
   logic [15:0] dones_wide;
   logic [7:0]  sones_wide;
   logic [3:0]  stens;
   logic [12:0] dtens_wide;
   logic [3:0]  dtens;
   logic        blink_on;

   // Stall a stage only when it holds an item the next one cannot take
   assign s2_ready = !s2_valid_ff || frame_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign full     = !s1_ready;
   assign accept   = push && s1_ready;

   // Advance the blink counter once per request
   assign phase_in = (phase_ff == lcdfb_pkg::BLINK_LAST) ? 4'd0 : phase_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // First divide by ten of distance and speed
   assign dist_prod = 32'(req_data.distance) * 32'(lcdfb_pkg::DIST_DIV10_MUL);
   assign spd_prod  = 16'(req_data.speed_value) * 16'(lcdfb_pkg::SPD_DIV10_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_snap_ff  <= req_data;
         s1_phase_ff <= phase_in;
         s1_dq_ff    <= dist_prod[lcdfb_pkg::DIST_DIV10_SHIFT +: 13];
         s1_sq_ff    <= spd_prod[lcdfb_pkg::SPD_DIV10_SHIFT +: 5];
      end
   end

   // Second divide by ten and the ones digits
   assign dq_prod    = 29'(s1_dq_ff) * 29'(lcdfb_pkg::DIST_DIV10_MUL);
   assign dones_wide = s1_snap_ff.distance - 16'(s1_dq_ff) * 16'(lcdfb_pkg::DIGIT_BASE);
   assign sones_wide = s1_snap_ff.speed_value - 8'(s1_sq_ff) * 8'(lcdfb_pkg::DIGIT_BASE);

   // Fold speed tens (at most 25) into one digit
   always_comb begin
      priority if (s1_sq_ff >= 5'd20) begin
         stens = 4'(s1_sq_ff - 5'd20);
      end else if (s1_sq_ff >= 5'd10) begin
         stens = 4'(s1_sq_ff - 5'd10);
      end else begin
         stens = 4'(s1_sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_snap_ff  <= s1_snap_ff;
         s2_phase_ff <= s1_phase_ff;
         s2_dq_ff    <= s1_dq_ff;
         s2_dqq_ff   <= dq_prod[lcdfb_pkg::DIST_DIV10_SHIFT +: 10];
         s2_dones_ff <= dones_wide[3:0];
         s2_sones_ff <= sones_wide[3:0];
         s2_stens_ff <= stens;
      end
   end

   assign dtens_wide = s2_dq_ff - 13'(s2_dqq_ff) * 13'(lcdfb_pkg::DIGIT_BASE);
   assign dtens      = dtens_wide[3:0];
   assign blink_on   = s2_phase_ff < lcdfb_pkg::BLINK_LIMIT;

   // Build the segment image
   always_comb begin
      frame = '0;
      if (s2_snap_ff.turn_left && blink_on) frame[7] |= lcdfb_pkg::SEG_TURN_LEFT;
      if (s2_snap_ff.turn_right && blink_on) frame[3] |= lcdfb_pkg::SEG_TURN_RIGHT;
      if (s2_snap_ff.near_light) frame[7] |= lcdfb_pkg::SEG_NEAR_LIGHT;
      if (s2_snap_ff.hall_error) frame[7] |= lcdfb_pkg::SEG_HALL_ERR;
      if (s2_snap_ff.handlebar_error) frame[7] |= lcdfb_pkg::SEG_BAR_ERR;
      if (s2_snap_ff.controller_error) frame[1] |= lcdfb_pkg::SEG_CTRL_ERR;
      if (s2_snap_ff.braked) frame[0] |= lcdfb_pkg::SEG_BRAKE;

      frame[4] |= lcdfb_pkg::SEG_BAT_FRAME;
      unique case (s2_snap_ff.battery_level)
         lcdfb_pkg::BAT_EMPTY: begin
            if (s2_phase_ff > lcdfb_pkg::BLINK_LIMIT) begin
               frame[4] &= ~lcdfb_pkg::SEG_BAT_FIRST;
            end
         end
         lcdfb_pkg::BAT_L1: frame[4] |= lcdfb_pkg::SEG_BAT_FIRST;
         lcdfb_pkg::BAT_L2: frame[4] |= lcdfb_pkg::SEG_BAT_L2;
         lcdfb_pkg::BAT_L3: frame[4] |= lcdfb_pkg::SEG_BAT_L3;
         lcdfb_pkg::BAT_L4: frame[4] |= lcdfb_pkg::SEG_BAT_L4;
         lcdfb_pkg::BAT_L5: frame[4] |= lcdfb_pkg::SEG_BAT_L5;
         default: ;
      endcase

      frame[5] |= lcdfb_pkg::dist_segments(s2_dones_ff);
      frame[6] |= lcdfb_pkg::dist_segments(dtens);
      if (s2_snap_ff.distance >= lcdfb_pkg::DIST_HUNDRED) frame[6] |= lcdfb_pkg::SEG_DIST_HUND;
      frame[4] |= lcdfb_pkg::SEG_DIST_UNIT;

      frame[1] |= lcdfb_pkg::speed_segments(s2_sones_ff);
      frame[0] |= lcdfb_pkg::speed_segments(s2_stens_ff);

      unique case (s2_snap_ff.speed_mode)
         lcdfb_pkg::MODE_1: frame[3] |= lcdfb_pkg::SEG_MODE1;
         lcdfb_pkg::MODE_2: frame[3] |= lcdfb_pkg::SEG_MODE2;
         lcdfb_pkg::MODE_3: frame[3] |= lcdfb_pkg::SEG_MODE3;
         lcdfb_pkg::MODE_4: frame[5] |= lcdfb_pkg::SEG_MODE4;
         default: begin
            frame[3] &= ~lcdfb_pkg::SEG_MODE_MASK3;
            frame[5] &= ~lcdfb_pkg::SEG_MODE4;
         end
      endcase
   end

   assign frame_valid = s2_valid_ff;

endmodule

FILE: hw/rtl/lcdfb_queue.sv
module lcdfb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  lcdfb_pkg::frame_type wr_frame,
   output logic                 rd_valid,
   input  logic                 rd_pop,
   output lcdfb_pkg::frame_type rd_frame
);

   localparam int PTR_W = (lcdfb_pkg::QUEUE_DEPTH > 1) ? $clog2(lcdfb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lcdfb_pkg::QUEUE_DEPTH + 1);

   lcdfb_pkg::frame_type entry_ff [lcdfb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr;
   logic             do_rd;

   assign wr_ready = count_ff != CNT_W'(lcdfb_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;
   assign rd_frame = entry_ff[rd_ptr_ff];

   // Store the frame
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_frame;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(lcdfb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(lcdfb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/lcdfb_back.sv
module lcdfb_back #(
   parameter int FRAME_BYTES = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid,
   output logic                 frame_pop,
   input  lcdfb_pkg::frame_type frame,
   output logic                 empty,
   input  logic                 pop,
   output lcdfb_pkg::rsp_type   rsp_data
);

   logic [lcdfb_pkg::INDEX_WIDTH-1:0] idx_ff;
   logic                              out_valid_ff;
   lcdfb_pkg::rsp_type                out_ff;
   lcdfb_pkg::rsp_type                out_in;
   logic                              load;
   logic                              at_last;

   assign load    = frame_valid && (!out_valid_ff || pop);
   assign at_last = idx_ff == lcdfb_pkg::INDEX_WIDTH'(FRAME_BYTES - 1);
   assign frame_pop = load && at_last;

   // Pick the next byte of the head frame
   always_comb begin
      out_in.byte_index   = idx_ff;
      out_in.segment_byte = (idx_ff < lcdfb_pkg::INDEX_WIDTH'(lcdfb_pkg::SEG_BYTES))
                            ? frame[idx_ff[lcdfb_pkg::SEG_IDX_W-1:0]] : 8'h00;
      out_in.last_byte    = at_last;
   end

   // Step the byte counter and hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff <= at_last ? '0 : idx_ff + 1'b1;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

FILE: hw/rtl/lcd_segment_frame_builder_top.sv
// LCD segment frame builder.
// Request channel: drive req_data with a vehicle status snapshot and raise
// push; the request is taken on a clock edge where push is high and full low.
// Response channel: while empty is low, rsp_data holds the oldest frame byte
// (index, segment bits, last-byte flag); raising pop takes it.
// Each request yields FRAME_BYTES responses, indexes 0 up to FRAME_BYTES-1,
// the last one flagged. Bytes past the eighth carry no segments.
// The first byte of a frame passes the front stage registers, the frame queue
// and the output byte register. Throughput: one byte per cycle while pop is
// held high, set by the single output byte register; the front stays open
// while a 2-frame queue has room, so requests overlap serializing old frames.
// Reset (synchronous) empties the pipeline and queue and sets the blink
// counter to zero; the counter advances on every request.
// When the receiver stalls, the output byte holds, the queue fills, and
// full rises once the front stages are occupied; nothing is dropped.
module lcd_segment_frame_builder_top #(
   parameter int FRAME_BYTES = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  lcdfb_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output lcdfb_pkg::rsp_type rsp_data
);

   logic                 fr_valid;
   logic                 fr_ready;
   lcdfb_pkg::frame_type fr_frame;
   logic                 q_valid;
   logic                 q_pop;
   lcdfb_pkg::frame_type q_frame;

   lcdfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .frame_valid (fr_valid),
      .frame_ready (fr_ready),
      .frame       (fr_frame)
   );

   lcdfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_frame (fr_frame),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_frame (q_frame)
   );

   lcdfb_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (q_valid),
      .frame_pop   (q_pop),
      .frame       (q_frame),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule
